// ----- sv/rse_pkg.sv -----
// Package for the row softmax engine: payload structs, exp table, constants.
// No dependencies; imported by all rse modules.
`default_nettype none
package rse_pkg;
    localparam int ROW_MAX_DEFAULT = 64;
    localparam logic [14:0] LOG2E_Q14 = 15'd23637;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               row_end;
    } rse_in_t;

    typedef struct packed {
        logic [15:0] probability;
        logic        last_of_row;
        logic        row_overflow;
    } rse_out_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // store s_data element, update max
        logic acc_clr;    // clear sum
        logic acc_en;     // add e of the read element to sum
        logic div_start;  // start reciprocal
        logic rd_en;      // issue store read at rd index
        logic row_clr;    // return row state to reset
    } rse_cmd_t;

    typedef struct packed {
        logic div_done;
    } rse_sts_t;

    function automatic logic [15:0] pow2_tab(input logic [4:0] k);
        logic [15:0] v;
        unique case (k)
            5'd0:  v = 16'd32768; 5'd1:  v = 16'd31379; 5'd2:  v = 16'd30048;
            5'd3:  v = 16'd28774; 5'd4:  v = 16'd27554; 5'd5:  v = 16'd26386;
            5'd6:  v = 16'd25268; 5'd7:  v = 16'd24196; 5'd8:  v = 16'd23170;
            5'd9:  v = 16'd22188; 5'd10: v = 16'd21247; 5'd11: v = 16'd20347;
            5'd12: v = 16'd19484; 5'd13: v = 16'd18658; 5'd14: v = 16'd17867;
            5'd15: v = 16'd17109; default: v = 16'd16384;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- sv/rse_exp.sv -----
// Two-stage exp unit: t*log2e scaling, then table interpolation and shift.
// Depends on rse_pkg.
`default_nettype none
module rse_exp import rse_pkg::*; (
    input  wire logic        aclk,
    input  wire logic [15:0] t,
    output logic      [15:0] e
);
    logic [31:0] prod;
    logic [17:0] z_reg;
    logic [17:0] z_next;
    logic [7:0]  f;
    logic [9:0]  n;
    logic [15:0] a, b, m;
    logic [19:0] dl;

    always_comb begin
        prod   = 32'(t) * 32'(LOG2E_Q14) + 32'd8192;
        z_next = prod[31:14];
    end
    always_ff @(posedge aclk) z_reg <= z_next;

    always_comb begin
        n  = z_reg[17:8];
        f  = z_reg[7:0];
        a  = pow2_tab({1'b0, f[7:4]});
        b  = pow2_tab({1'b0, f[7:4]} + 5'd1);
        dl = 20'(a - b) * 20'(f[3:0]) + 20'd8;
        m  = a - 16'(dl[19:4]);
        e  = (n >= 10'd16) ? 16'd0 : (m >> n[3:0]);
    end
endmodule
`default_nettype wire

// ----- sv/rse_datapath.sv -----
// Datapath: row store, running max, exp, sum, serial reciprocal, output product.
// Depends on rse_pkg and rse_exp.
`default_nettype none
module rse_datapath import rse_pkg::*; #(
    parameter int ROW_MAX = ROW_MAX_DEFAULT,
    parameter int IW = $clog2(ROW_MAX)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rse_cmd_t      cmd,
    input  wire rse_in_t       in_data,
    input  wire logic [IW-1:0] wr_idx,
    input  wire logic [IW-1:0] rd_idx,
    output rse_sts_t           sts,
    output logic      [15:0]   prob
);
    logic [15:0] mem [ROW_MAX];
    logic [15:0] rd_reg;
    logic signed [15:0] max_reg;
    logic [15:0] t_reg;
    logic [15:0] e;
    logic [15:0] e_reg;
    logic [IW+15:0] sum_reg;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] q_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [48:0] p;

    always_ff @(posedge aclk) begin
        if (cmd.load) mem[wr_idx] <= in_data.logit;
        if (cmd.rd_en) rd_reg <= mem[rd_idx];
        t_reg <= 16'($signed(max_reg) - $signed(rd_reg));
        e_reg <= e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.row_clr) max_reg <= -16'sd32768;
        else if (cmd.load && in_data.logit > max_reg) max_reg <= in_data.logit;
    end

    rse_exp u_exp (.aclk(aclk), .t(t_reg), .e(e));

    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) sum_reg <= '0;
        else if (cmd.acc_en) sum_reg <= sum_reg + (IW+16)'(e_reg);
    end

    // restoring division 2^32 / sum, one quotient bit a cycle
    always_comb begin
        rem_next = {rem_reg[31:0], (dcnt_reg == 6'd32)};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= 6'd32;
            rem_reg   <= '0;
            q_reg     <= '0;
        end else if (dbusy_reg) begin
            if (rem_next >= 33'(sum_reg)) begin
                rem_reg <= rem_next - 33'(sum_reg);
                q_reg   <= {q_reg[31:0], 1'b1};
            end else begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[31:0], 1'b0};
            end
            if (dcnt_reg == 6'd0) dbusy_reg <= 1'b0;
            else dcnt_reg <= dcnt_reg - 6'd1;
        end
    end
    assign sts.div_done = dbusy_reg && dcnt_reg == 6'd0;

    always_comb begin
        p = 49'(e_reg) * 49'(q_reg) + 49'd32768;
        prob = (p[48:32] != '0) ? 16'hFFFF : p[31:16];
    end
endmodule
`default_nettype wire

// ----- sv/rse_ctrl.sv -----
// Controller: load, sum pass, reciprocal wait, emit pass with output register.
// Depends on rse_pkg.
`default_nettype none
module rse_ctrl import rse_pkg::*; #(
    parameter int ROW_MAX = ROW_MAX_DEFAULT,
    parameter int IW = $clog2(ROW_MAX)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rse_in_t       s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rse_out_t           m_data,
    input  wire logic [15:0]   prob,
    input  wire rse_sts_t      sts,
    output rse_cmd_t           cmd,
    output logic [IW-1:0]      wr_idx,
    output logic [IW-1:0]      rd_idx
);
    typedef enum logic [2:0] {LOAD, SUM, DIV, ISSUE, WAIT, HOLD} state_t;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] FULL = CW'(ROW_MAX);
    localparam logic [3:0] LAT = 4'd4; // read, t, z, e registers

    state_t state_reg;
    logic [CW-1:0] cnt_reg, ptr_reg;
    logic [3:0] pipe_reg;
    logic ovf_reg;
    logic acc_pipe_reg [4];
    logic acc_any;
    logic s_acc;

    assign s_ready = state_reg == LOAD;
    assign s_acc = s_valid && s_ready;
    assign wr_idx = cnt_reg[IW-1:0];
    assign rd_idx = ptr_reg[IW-1:0];

    always_comb begin
        cmd = '0;
        cmd.load = s_acc && cnt_reg < FULL;
        cmd.rd_en = (state_reg == SUM && ptr_reg < cnt_reg) || state_reg == ISSUE;
        cmd.acc_clr = s_acc && s_data.row_end;
        cmd.acc_en = acc_pipe_reg[3];
        acc_any = acc_pipe_reg[0] | acc_pipe_reg[1] | acc_pipe_reg[2] | acc_pipe_reg[3];
        cmd.div_start = state_reg == SUM && ptr_reg >= cnt_reg && !acc_any;
        cmd.row_clr = state_reg == HOLD && m_ready && ptr_reg >= cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOAD;
            cnt_reg <= '0;
            ptr_reg <= '0;
            ovf_reg <= 1'b0;
            m_valid <= 1'b0;
            pipe_reg <= '0;
            for (int i = 0; i < 4; i++) acc_pipe_reg[i] <= 1'b0;
        end else begin
            acc_pipe_reg[0] <= state_reg == SUM && ptr_reg < cnt_reg;
            for (int i = 1; i < 4; i++) acc_pipe_reg[i] <= acc_pipe_reg[i-1];
            unique case (state_reg)
                LOAD: if (s_acc) begin
                    if (cnt_reg < FULL) cnt_reg <= cnt_reg + CW'(1);
                    else ovf_reg <= 1'b1;
                    if (s_data.row_end) begin
                        state_reg <= SUM;
                        ptr_reg <= '0;
                    end
                end
                SUM: begin
                    if (ptr_reg < cnt_reg) ptr_reg <= ptr_reg + CW'(1);
                    else if (!acc_any) state_reg <= DIV;
                end
                DIV: if (sts.div_done) begin
                    state_reg <= ISSUE;
                    ptr_reg <= '0;
                end
                ISSUE: begin
                    state_reg <= WAIT;
                    pipe_reg <= LAT;
                end
                WAIT: begin
                    // drain one-entry pipeline, then latch product
                    if (pipe_reg == 4'd1) begin
                        state_reg <= HOLD;
                        m_valid <= 1'b1;
                        m_data.probability <= prob;
                        m_data.last_of_row <= ptr_reg + CW'(1) == cnt_reg;
                        m_data.row_overflow <= ovf_reg;
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                    pipe_reg <= pipe_reg - 4'd1;
                end
                HOLD: if (m_ready) begin
                    m_valid <= 1'b0;
                    if (ptr_reg >= cnt_reg) begin
                        state_reg <= LOAD;
                        cnt_reg <= '0;
                        ovf_reg <= 1'b0;
                    end else begin
                        state_reg <= ISSUE;
                    end
                end
                default: state_reg <= LOAD;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during emit");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL) else $error("row count past capacity");
endmodule
`default_nettype wire

// ----- sv/row_softmax_engine.sv -----
// Row softmax engine top level: controller plus datapath.
// Depends on rse_pkg, rse_ctrl, rse_datapath.
//
// Input channel s_valid/s_ready/s_data carries logits (Q8.8) with a row_end
// flag; elements beyond ROW_MAX are dropped and flag row_overflow.
// Loading accepts one element per cycle. After row_end the block reads the
// row once to sum exp values, runs a serial reciprocal, then emits one
// probability (Q0.16) per element on m_valid/m_ready/m_data; each result
// passes through the store read and the two-stage exp unit, and the next
// element is not read until the receiver has taken the result.
// s_ready is low from row_end until the last result is taken.
// When the receiver stalls, the result holds in the output register.
// Reset (aresetn low, synchronous) empties the row and drops pending results.
`default_nettype none
module row_softmax_engine import rse_pkg::*; #(
    parameter int ROW_MAX = ROW_MAX_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire rse_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rse_out_t      m_data
);
    localparam int IW = $clog2(ROW_MAX);
    rse_cmd_t cmd;
    rse_sts_t sts;
    logic [IW-1:0] wr_idx, rd_idx;
    logic [15:0] prob;

    rse_ctrl #(.ROW_MAX(ROW_MAX), .IW(IW)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready,
        .m_data, .prob, .sts, .cmd, .wr_idx, .rd_idx);

    rse_datapath #(.ROW_MAX(ROW_MAX), .IW(IW)) u_dp (
        .aclk, .aresetn, .cmd, .in_data(s_data), .wr_idx, .rd_idx, .sts, .prob);
endmodule
`default_nettype wire
